[hw/rtl/rec_pkg.sv]
// Shared constants and types for the rotor effectiveness column datapath.
// Depends on nothing; used by rec_isqrt, rec_divide, rotor_effectiveness_column and the testbench.
`default_nettype none

package rec_pkg;

  localparam int unsigned MaxRotors  = 12;
  localparam int unsigned MaxColumns = 16;

  localparam int unsigned ColW  = 4;   // column / rotor index
  localparam int unsigned FixW  = 16;  // input fixed-point fields
  localparam int unsigned ResW  = 32;  // Q15.16 results
  localparam int unsigned AddrW = 4;   // APB byte address

  localparam int unsigned NormW    = 48;  // squared length, scaled by 2^16
  localparam int unsigned RootW    = 24;  // floor sqrt of the above
  localparam int unsigned SqRemW   = 26;  // sqrt partial remainder
  localparam int unsigned QuotW    = 32;  // unit axis quotient, one extra fraction bit
  localparam int unsigned UnitW    = 32;  // unit axis, Q2.30
  localparam int unsigned DivShift = 7;   // dividend |d|*2^39: high word |d|<<7, low word zero

  typedef enum logic [1:0] {
    RegColStart   = 2'd0,
    RegRotorCount = 2'd1,
    RegYawOff     = 2'd2
  } reg_idx_e;

  typedef logic signed [FixW-1:0] fix_t;
  typedef logic [FixW-1:0]        mag_t;

  // per-rotor data carried alongside the norm / divide pipelines
  typedef struct packed {
    logic [ColW-1:0] column;
    logic            counted;
    logic            wr;
    fix_t [2:0]      pos;
    logic [2:0]      dir_neg;
    mag_t [2:0]      dir_mag;
    fix_t            ct;
    fix_t            km;
  } side_t;

endpackage

`default_nettype wire

[hw/rtl/rec_isqrt.sv]
// Pipelined integer square root, one result bit per stage, carries rotor data along.
// Depends on rec_pkg.
`default_nettype none

module rec_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        in_valid_i,
  input  logic [rec_pkg::NormW-1:0]   rad_i,
  input  rec_pkg::side_t              side_i,
  output logic                        out_valid_o,
  output logic [rec_pkg::RootW-1:0]   root_o,
  output rec_pkg::side_t              side_o
);

  localparam int unsigned NormW = rec_pkg::NormW;
  localparam int unsigned RootW = rec_pkg::RootW;
  localparam int unsigned RemW  = rec_pkg::SqRemW;
  localparam int unsigned Steps = RootW;

  typedef struct packed {
    logic [NormW-1:0] rad;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sq_st_t;

  // one digit pair of the classic shift-subtract root
  function automatic sq_st_t sq_step(sq_st_t s);
    sq_st_t           n;
    logic [RemW+1:0]  rem_sh;
    logic [RemW+1:0]  trial;
    rem_sh = {s.rem, s.rad[NormW-1 -: 2]};
    trial  = {{(RemW-RootW){1'b0}}, s.root, 2'b01};
    if (rem_sh >= trial) begin
      n.rem  = RemW'(rem_sh - trial);
      n.root = {s.root[RootW-2:0], 1'b1};
    end else begin
      n.rem  = RemW'(rem_sh);
      n.root = {s.root[RootW-2:0], 1'b0};
    end
    n.rad = {s.rad[NormW-3:0], 2'b00};
    return n;
  endfunction

  logic [Steps-1:0] v_q;
  sq_st_t           st_q   [Steps];
  sq_st_t           st_d   [Steps];
  rec_pkg::side_t   side_q [Steps];

  always_comb begin
    sq_st_t s0;
    s0.rad  = rad_i;
    s0.rem  = '0;
    s0.root = '0;
    st_d[0] = sq_step(s0);
    for (int k = 1; k < Steps; k++) begin
      st_d[k] = sq_step(st_q[k-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[Steps-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 0; k < Steps; k++) begin
        st_q[k] <= st_d[k];
      end
      for (int k = 1; k < Steps; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign out_valid_o = v_q[Steps-1];
  assign root_o      = st_q[Steps-1].root;
  assign side_o      = side_q[Steps-1];

endmodule

`default_nettype wire

[hw/rtl/rec_divide.sv]
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
// Depends on rec_pkg.
`default_nettype none

module rec_divide (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              in_valid_i,
  input  logic [rec_pkg::RootW-1:0]         den_i,
  input  rec_pkg::side_t                    side_i,
  output logic                              out_valid_o,
  output logic [2:0][rec_pkg::QuotW-1:0]    quo_o,
  output rec_pkg::side_t                    side_o
);

  localparam int unsigned RootW    = rec_pkg::RootW;
  localparam int unsigned QuotW    = rec_pkg::QuotW;
  localparam int unsigned DivShift = rec_pkg::DivShift;
  localparam int unsigned Steps    = QuotW;

  typedef struct packed {
    logic [RootW-1:0]            den;
    logic [2:0][RootW-1:0]       rem;
    logic [2:0][QuotW-1:0]       quo;
  } dv_st_t;

  // shifted-in dividend bits are all zero
  function automatic dv_st_t dv_step(dv_st_t s);
    dv_st_t         n;
    logic [RootW:0] r_sh;
    n.den = s.den;
    for (int j = 0; j < 3; j++) begin
      r_sh = {s.rem[j], 1'b0};
      if (r_sh >= {1'b0, s.den}) begin
        n.rem[j] = RootW'(r_sh - {1'b0, s.den});
        n.quo[j] = {s.quo[j][QuotW-2:0], 1'b1};
      end else begin
        n.rem[j] = RootW'(r_sh);
        n.quo[j] = {s.quo[j][QuotW-2:0], 1'b0};
      end
    end
    return n;
  endfunction

  logic [Steps-1:0] v_q;
  dv_st_t           st_q   [Steps];
  dv_st_t           st_d   [Steps];
  rec_pkg::side_t   side_q [Steps];

  always_comb begin
    dv_st_t s0;
    s0.den = den_i;
    for (int j = 0; j < 3; j++) begin
      s0.rem[j] = RootW'({side_i.dir_mag[j], {DivShift{1'b0}}});
      s0.quo[j] = '0;
    end
    st_d[0] = dv_step(s0);
    for (int k = 1; k < Steps; k++) begin
      st_d[k] = dv_step(st_q[k-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[Steps-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 0; k < Steps; k++) begin
        st_q[k] <= st_d[k];
      end
      for (int k = 1; k < Steps; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign out_valid_o = v_q[Steps-1];
  assign quo_o       = st_q[Steps-1].quo;
  assign side_o      = side_q[Steps-1];

endmodule

`default_nettype wire

[hw/rtl/rotor_effectiveness_column.sv]
// Rotor effectiveness column: one rotor in, one effectiveness-matrix column out.
// Throughput: one rotor per cycle while the skid slot is empty; 24 root stages
// and 32 divide stages set the depth.
// Reset (rst_ni low, asynchronous) empties the pipeline and clears all three registers.
// Depends on rec_pkg, rec_isqrt and rec_divide.
`default_nettype none

module rotor_effectiveness_column (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // APB-style register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rec_pkg::AddrW-1:0]    paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // rotor description
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [3:0]                   rotor_number_i,
  input  logic signed [15:0]           pos_x_i,
  input  logic signed [15:0]           pos_y_i,
  input  logic signed [15:0]           pos_z_i,
  input  logic signed [15:0]           dir_x_i,
  input  logic signed [15:0]           dir_y_i,
  input  logic signed [15:0]           dir_z_i,
  input  logic signed [15:0]           thrust_gain_i,
  input  logic signed [15:0]           torque_ratio_i,
  // matrix column
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [3:0]                   column_o,
  output logic                         counted_o,
  output logic                         write_column_o,
  output logic signed [31:0]           moment_x_o,
  output logic signed [31:0]           moment_y_o,
  output logic signed [31:0]           moment_z_o,
  output logic signed [31:0]           force_x_o,
  output logic signed [31:0]           force_y_o,
  output logic signed [31:0]           force_z_o
);

  localparam int unsigned ColW   = rec_pkg::ColW;
  localparam int unsigned FixW   = rec_pkg::FixW;
  localparam int unsigned ResW   = rec_pkg::ResW;
  localparam int unsigned NormW  = rec_pkg::NormW;
  localparam int unsigned RootW  = rec_pkg::RootW;
  localparam int unsigned QuotW  = rec_pkg::QuotW;
  localparam int unsigned UnitW  = rec_pkg::UnitW;
  localparam int unsigned SqW    = 2 * FixW;           // |d|^2 and their sum
  localparam int unsigned ProdW  = FixW + UnitW;       // 16 x 32 products
  localparam int unsigned WideW  = ProdW + 2;          // 4*cross - km*u
  localparam int unsigned HalfW  = WideW / 2;          // split of |w| for the ct multiply
  localparam int unsigned PartW  = HalfW + FixW;
  localparam int unsigned SumW   = PartW + HalfW;
  localparam int unsigned RndLsb = 34;                 // |w*ct| >> 34, then round by one bit
  localparam int unsigned RndW   = SumW - 1 - RndLsb;
  localparam int unsigned FrcLsb = 21;                 // |ct*u| >> 21, then round by one bit
  localparam int unsigned FrcW   = ProdW - FrcLsb;

  typedef struct packed {
    logic [ColW-1:0]      column;
    logic                 counted;
    logic                 wr;
    logic [2:0][ResW-1:0] moment;
    logic [2:0][ResW-1:0] frc;
  } res_t;

  // ---------------------------------------------------------------------------
  // Register file. Writes land on the access phase; pready is tied high.
  // ---------------------------------------------------------------------------
  logic [ColW-1:0] col_start_q;
  logic [ColW-1:0] rotor_count_q;
  logic            yaw_off_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_start_q   <= '0;
      rotor_count_q <= '0;
      yaw_off_q     <= 1'b0;
    end else if (cfg_wr) begin
      case (rec_pkg::reg_idx_e'(paddr[3:2]))
        rec_pkg::RegColStart:   col_start_q   <= pwdata[ColW-1:0];
        rec_pkg::RegRotorCount: rotor_count_q <= pwdata[ColW-1:0];
        rec_pkg::RegYawOff:     yaw_off_q     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (rec_pkg::reg_idx_e'(paddr[3:2]))
      rec_pkg::RegColStart:   prdata = 32'(col_start_q);
      rec_pkg::RegRotorCount: prdata = 32'(rotor_count_q);
      rec_pkg::RegYawOff:     prdata = 32'(yaw_off_q);
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Flow control. The whole pipeline advances together while the skid slot
  // is empty, so in_ready_o comes straight from a flop. A result that meets
  // a busy output register parks in the skid slot and freezes the pipe.
  // ---------------------------------------------------------------------------
  logic en;
  logic out_v_q, sk_v_q;
  res_t out_q, sk_q;

  assign en         = !sk_v_q;
  assign in_ready_o = en;

  // ---------------------------------------------------------------------------
  // Front end: range checks, column, axis magnitudes and their squares.
  // ---------------------------------------------------------------------------
  rec_pkg::fix_t [2:0] pos_in, dir_in;
  logic [ColW:0]       col_sum;
  logic                counted;
  rec_pkg::side_t      side_d;
  logic [2:0][SqW-1:0] sq_d;

  assign pos_in = {pos_z_i, pos_y_i, pos_x_i};
  assign dir_in = {dir_z_i, dir_y_i, dir_x_i};

  always_comb begin
    col_sum = {1'b0, col_start_q} + {1'b0, rotor_number_i};
    // rotor beyond the geometry or column beyond the matrix: not counted
    counted = (32'(rotor_number_i) < rec_pkg::MaxRotors) &&
              (rotor_number_i < rotor_count_q) &&
              (32'(col_sum) < rec_pkg::MaxColumns);
    side_d.column  = counted ? col_sum[ColW-1:0] : '0;
    side_d.counted = counted;
    // zero axis or zero ct: counted but the column stays unwritten
    side_d.wr      = counted && (dir_in != '0) && (thrust_gain_i != '0);
    side_d.pos     = pos_in;
    side_d.ct      = thrust_gain_i;
    side_d.km      = yaw_off_q ? '0 : torque_ratio_i;
    for (int j = 0; j < 3; j++) begin
      side_d.dir_neg[j] = dir_in[j][FixW-1];
      side_d.dir_mag[j] = dir_in[j][FixW-1] ? (~dir_in[j] + 1'b1) : dir_in[j];
      sq_d[j]           = side_d.dir_mag[j] * side_d.dir_mag[j];
    end
  end

  logic                s1_v_q;
  rec_pkg::side_t      s1_side_q;
  logic [2:0][SqW-1:0] s1_sq_q;
  logic [SqW-1:0]      n2;
  logic [NormW-1:0]    rad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_side_q <= side_d;
      s1_sq_q   <= sq_d;
    end
  end

  // sum of squares fits 32 bits; scaled by 2^16 so the root carries 8 fraction bits
  assign n2  = s1_sq_q[0] + s1_sq_q[1] + s1_sq_q[2];
  assign rad = {n2, {(NormW-SqW){1'b0}}};

  // ---------------------------------------------------------------------------
  // Norm and unit axis: root pipeline, then three divide lanes giving
  // |d_i| * 2^39 / N, i.e. the unit axis with one extra fraction bit.
  // ---------------------------------------------------------------------------
  logic                  sq_v;
  logic [RootW-1:0]      sq_root;
  rec_pkg::side_t        sq_side;
  logic                  dv_v;
  logic [2:0][QuotW-1:0] dv_quo;
  rec_pkg::side_t        dv_side;

  rec_isqrt u_isqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (s1_v_q),
    .rad_i       (rad),
    .side_i      (s1_side_q),
    .out_valid_o (sq_v),
    .root_o      (sq_root),
    .side_o      (sq_side)
  );

  rec_divide u_divide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (sq_v),
    .den_i       (sq_root),
    .side_i      (sq_side),
    .out_valid_o (dv_v),
    .quo_o       (dv_quo),
    .side_o      (dv_side)
  );

  // ---------------------------------------------------------------------------
  // Arithmetic tail, five stages after the unit-axis rounding:
  //   U : u = round(q/2), signed                     (Q2.30)
  //   M1: p_a*u_b, p_b*u_a, km*u, ct*u
  //   M2: w = 4*cross - km*u; force rounded from ct*u
  //   M3: |w| split in halves times |ct|
  //   M4: partial products summed, >> 34
  //   M5: final rounding bit, sign, unwritten columns forced to zero
  // Neither path can leave the 32-bit range, so no clamping is needed.
  // ---------------------------------------------------------------------------
  logic                  u_v_q, m1_v_q, m2_v_q, m3_v_q, m4_v_q, m5_v_q;
  rec_pkg::side_t        u_side_q, m1_side_q, m2_side_q, m3_side_q, m4_side_q;
  logic [2:0][UnitW-1:0] u_d, u_q;
  res_t                  m5_d, m5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_v_q  <= 1'b0;
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
      m3_v_q <= 1'b0;
      m4_v_q <= 1'b0;
      m5_v_q <= 1'b0;
    end else if (en) begin
      u_v_q  <= dv_v;
      m1_v_q <= u_v_q;
      m2_v_q <= m1_v_q;
      m3_v_q <= m2_v_q;
      m4_v_q <= m3_v_q;
      m5_v_q <= m4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_side_q  <= dv_side;
      u_q       <= u_d;
      m1_side_q <= u_side_q;
      m2_side_q <= m1_side_q;
      m3_side_q <= m2_side_q;
      m4_side_q <= m3_side_q;
      m5_q      <= m5_d;
    end
  end

  assign m5_d.column  = m4_side_q.column;
  assign m5_d.counted = m4_side_q.counted;
  assign m5_d.wr      = m4_side_q.wr;

  for (genvar j = 0; j < 3; j++) begin : g_lane
    localparam int unsigned A = (j + 1) % 3;
    localparam int unsigned B = (j + 2) % 3;

    logic [QuotW:0]           q_rnd;
    logic signed [ProdW-1:0]  c1_d, c2_d, ku_d, cu_d;
    logic signed [ProdW-1:0]  c1_q, c2_q, ku_q, cu_q;
    logic signed [WideW-1:0]  w_d, w_q;
    logic [ProdW-1:0]         cu_mag;
    logic [FrcW:0]            fr_rnd;
    logic [ResW-1:0]          frc_d, frc_q, frc3_q, frc4_q;
    logic [WideW-1:0]         w_mag;
    logic [FixW-1:0]          ct_mag;
    logic [PartW-1:0]         pl_d, ph_d, pl_q, ph_q;
    logic                     neg_d, neg3_q, neg4_q;
    logic [SumW-1:0]          p_sum;
    logic [RndW-1:0]          sh_q;
    logic [RndW:0]            mm_rnd;
    logic [ResW-1:0]          mom;

    // U: ties away from zero on the magnitude, then the axis sign
    assign q_rnd  = {1'b0, dv_quo[j]} + 1'b1;
    assign u_d[j] = dv_side.dir_neg[j] ? UnitW'(-q_rnd[QuotW:1]) : UnitW'(q_rnd[QuotW:1]);

    // M1
    assign c1_d = $signed(u_side_q.pos[A]) * $signed(u_q[B]);
    assign c2_d = $signed(u_side_q.pos[B]) * $signed(u_q[A]);
    assign ku_d = $signed(u_side_q.km) * $signed(u_q[j]);
    assign cu_d = $signed(u_side_q.ct) * $signed(u_q[j]);

    // M2
    assign w_d    = ((WideW'(c1_q) - WideW'(c2_q)) <<< 2) - WideW'(ku_q);
    assign cu_mag = cu_q[ProdW-1] ? ProdW'(-cu_q) : ProdW'(cu_q);
    assign fr_rnd = {1'b0, cu_mag[ProdW-1:FrcLsb]} + 1'b1;
    assign frc_d  = cu_q[ProdW-1] ? ResW'(-ResW'(fr_rnd[FrcW:1])) : ResW'(fr_rnd[FrcW:1]);

    // M3
    assign w_mag  = w_q[WideW-1] ? WideW'(-w_q) : WideW'(w_q);
    assign ct_mag = m2_side_q.ct[FixW-1] ? (~m2_side_q.ct + 1'b1) : m2_side_q.ct;
    assign pl_d   = PartW'(w_mag[HalfW-1:0]) * PartW'(ct_mag);
    assign ph_d   = PartW'(w_mag[WideW-1:HalfW]) * PartW'(ct_mag);
    assign neg_d  = w_q[WideW-1] ^ m2_side_q.ct[FixW-1];

    // M4
    assign p_sum = {ph_q, {HalfW{1'b0}}} + SumW'(pl_q);

    // M5
    assign mm_rnd = {1'b0, sh_q} + 1'b1;
    assign mom    = neg4_q ? ResW'(-ResW'(mm_rnd[RndW:1])) : ResW'(mm_rnd[RndW:1]);

    assign m5_d.moment[j] = m4_side_q.wr ? mom : '0;
    assign m5_d.frc[j]    = m4_side_q.wr ? frc4_q : '0;

    always_ff @(posedge clk_i) begin
      if (en) begin
        c1_q   <= c1_d;
        c2_q   <= c2_d;
        ku_q   <= ku_d;
        cu_q   <= cu_d;
        w_q    <= w_d;
        frc_q  <= frc_d;
        pl_q   <= pl_d;
        ph_q   <= ph_d;
        neg3_q <= neg_d;
        frc3_q <= frc_q;
        sh_q   <= p_sum[RndLsb +: RndW];
        neg4_q <= neg3_q;
        frc4_q <= frc3_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register plus skid slot.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else if (en) begin
      if (!out_v_q || out_ready_i) begin
        out_v_q <= m5_v_q;
      end else if (m5_v_q) begin
        sk_v_q <= 1'b1;
      end
    end else if (out_ready_i) begin
      out_v_q <= 1'b1;
      sk_v_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (!out_v_q || out_ready_i) begin
        out_q <= m5_q;
      end else begin
        sk_q <= m5_q;
      end
    end else if (out_ready_i) begin
      out_q <= sk_q;
    end
  end

  assign out_valid_o    = out_v_q;
  assign column_o       = out_q.column;
  assign counted_o      = out_q.counted;
  assign write_column_o = out_q.wr;
  assign moment_x_o     = $signed(out_q.moment[0]);
  assign moment_y_o     = $signed(out_q.moment[1]);
  assign moment_z_o     = $signed(out_q.moment[2]);
  assign force_x_o      = $signed(out_q.frc[0]);
  assign force_y_o      = $signed(out_q.frc[1]);
  assign force_z_o      = $signed(out_q.frc[2]);

`ifndef SYNTHESIS
  // a parked result always sits behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_v_q |-> out_v_q)
    else $error("skid slot full with empty output register");

  // a written column needs a nonzero norm entering the divider
  a_norm_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sq_v && sq_side.wr) |-> (sq_root >= RootW'(256)))
    else $error("norm too small for a written column");

  a_unwritten_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !write_column_o) |->
      (moment_x_o == 0 && moment_y_o == 0 && moment_z_o == 0 &&
       force_x_o == 0 && force_y_o == 0 && force_z_o == 0))
    else $error("unwritten column carries values");

  a_written_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && write_column_o) |-> counted_o)
    else $error("written column not counted");

  a_uncounted_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !counted_o) |-> (column_o == '0))
    else $error("uncounted rotor with nonzero column");
`endif

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for rotor_effectiveness_column: rotor transfers in,
// matrix column transfers out, scored against an in-bench fixed-point predictor.
// Depends on rec_pkg and the rotor_effectiveness_column RTL.

module testbench;

  import rec_pkg::*;

  localparam int unsigned QuietLimit = 4000;  // cycles with no transfer before giving up
  localparam int unsigned TailCycles = 80;    // longer than the pipeline's input-to-output path
  localparam logic [AddrW-1:0] BadRegAddr = 4'd12;  // no register lives here

  typedef struct {
    logic [3:0]         rotor;
    logic signed [15:0] pos [3];
    logic signed [15:0] dir [3];
    logic signed [15:0] ct;
    logic signed [15:0] km;
  } rotor_t;

  typedef struct {
    logic [3:0]         column;
    logic               counted;
    logic               wr;
    logic signed [31:0] moment [3];
    logic signed [31:0] force_v [3];
  } column_t;

  // Holds the register copy, predicts each column and checks the DUT output.
  class column_scoreboard;
    int unsigned start_col, rotor_cnt, yaw_off;
    column_t     expected_cols [$];
    int unsigned errors;

    function new();
      start_col = 0;
      rotor_cnt = 0;
      yaw_off   = 0;
      errors    = 0;
    endfunction

    function void set_reg(logic [AddrW-1:0] addr, logic [31:0] data);
      case (addr)
        {RegColStart, 2'b00}:   start_col = data[3:0];
        {RegRotorCount, 2'b00}: rotor_cnt = data[3:0];
        {RegYawOff, 2'b00}:     yaw_off   = data[0];
        default: ;
      endcase
    endfunction

    function bit [63:0] root64(bit [63:0] v);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // nearest, ties away from zero
    function longint shift_round(longint v, int s);
      bit [63:0] m;
      m = (v < 0) ? -v : v;
      m = ((m >> (s - 1)) + 1) >> 1;
      return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function longint div_round(longint a, bit [63:0] n);
      bit [63:0] m;
      m = (a < 0) ? -a : a;
      m = (2 * m + n) / (2 * n);
      return (a < 0) ? -longint'(m) : longint'(m);
    endfunction

    function logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    // accepted rotor transfer: work out its column
    function void note_rotor(rotor_t it);
      column_t   c;
      int unsigned lim, col;
      longint    p [3], d [3], u [3], ct, km, cr, w, m;
      bit [63:0] n2, nq, wm, cm, mm;
      int        a, b;
      c.column = 0; c.counted = 0; c.wr = 0;
      for (int j = 0; j < 3; j++) begin
        c.moment[j] = 0;
        c.force_v[j] = 0;
      end
      lim = (rotor_cnt < MaxRotors) ? rotor_cnt : MaxRotors;
      col = start_col + it.rotor;
      if (it.rotor < lim && col < MaxColumns) begin
        c.column  = col[3:0];
        c.counted = 1;
        for (int j = 0; j < 3; j++) begin
          p[j] = it.pos[j];
          d[j] = it.dir[j];
        end
        ct = it.ct;
        km = yaw_off ? 0 : longint'(it.km);
        if (!((d[0] == 0 && d[1] == 0 && d[2] == 0) || ct == 0)) begin
          n2 = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
          nq = root64(n2 << 16);
          for (int j = 0; j < 3; j++) u[j] = div_round(d[j] * (64'sd1 <<< 38), nq);
          for (int j = 0; j < 3; j++) begin
            a  = (j + 1) % 3;
            b  = (j + 2) % 3;
            cr = p[a] * u[b] - p[b] * u[a];
            w  = 4 * cr - km * u[j];
            wm = (w < 0) ? -w : w;
            cm = (ct < 0) ? -ct : ct;
            mm = (((wm * cm) >> 34) + 1) >> 1;
            m  = ((w < 0) != (ct < 0)) ? -longint'(mm) : longint'(mm);
            c.moment[j]  = clamp32(m);
            c.force_v[j] = clamp32(shift_round(ct * u[j], 22));
          end
          c.wr = 1;
        end
      end
      expected_cols.push_back(c);
    endfunction

    function void check_column(column_t got);
      column_t exp_c;
      longint  e [9], g [9];
      string   nm [9] = '{"column", "counted", "write_column", "moment_x", "moment_y",
                          "moment_z", "force_x", "force_y", "force_z"};
      if (expected_cols.size() == 0) begin
        $display("%0t: unexpected column transfer, column %0d", $time, got.column);
        errors++;
        return;
      end
      exp_c = expected_cols.pop_front();
      e[0] = exp_c.column; e[1] = exp_c.counted; e[2] = exp_c.wr;
      g[0] = got.column;   g[1] = got.counted;   g[2] = got.wr;
      for (int j = 0; j < 3; j++) begin
        e[3 + j] = exp_c.moment[j]; e[6 + j] = exp_c.force_v[j];
        g[3 + j] = got.moment[j];   g[6 + j] = got.force_v[j];
      end
      for (int k = 0; k < 9; k++)
        if (e[k] != g[k]) begin
          $display("%0t: %s mismatch, expected %0d, got %0d", $time, nm[k], e[k], g[k]);
          errors++;
        end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic psel, penable, pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid_i, in_ready_o;
  logic [3:0] rotor_number_i;
  logic signed [15:0] pos_x_i, pos_y_i, pos_z_i, dir_x_i, dir_y_i, dir_z_i;
  logic signed [15:0] thrust_gain_i, torque_ratio_i;
  logic out_valid_o, out_ready_i;
  logic [3:0] column_o;
  logic counted_o, write_column_o;
  logic signed [31:0] moment_x_o, moment_y_o, moment_z_o, force_x_o, force_y_o, force_z_o;

  column_scoreboard sb = new();
  int unsigned send_idle_pct, recv_stall_pct;
  int unsigned quiet_cycles;

  rotor_effectiveness_column u_dut (.*);

  always begin
    clk_i = 1'b1; #6;
    clk_i = 1'b0; #6;
  end

  // Output side: random back-pressure, scoring and the no-progress watchdog.
  always @(posedge clk_i) begin
    column_t got;
    if (out_valid_o && out_ready_i) begin
      got.column = column_o; got.counted = counted_o; got.wr = write_column_o;
      got.moment = '{moment_x_o, moment_y_o, moment_z_o};
      got.force_v = '{force_x_o, force_y_o, force_z_o};
      sb.check_column(got);
    end
    if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o) || !rst_ni)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("simulation failed");
      $finish;
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // setup then access; the register takes the value on the access edge
  task automatic reg_write(logic [AddrW-1:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.set_reg(addr, data);
  endtask

  // input side goes quiet first so nothing is in flight while registers change
  task automatic configure(int unsigned start, int unsigned cnt, int unsigned yaw);
    in_valid_i <= 1'b0;
    while (sb.expected_cols.size() != 0) @(posedge clk_i);
    reg_write({RegColStart, 2'b00}, start);
    reg_write({RegRotorCount, 2'b00}, cnt);
    reg_write({RegYawOff, 2'b00}, yaw);
  endtask

  // one rotor transfer; valid only drops when an idle gap is taken
  task automatic send_rotor(rotor_t it);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rotor_number_i <= it.rotor;
    pos_x_i <= it.pos[0]; pos_y_i <= it.pos[1]; pos_z_i <= it.pos[2];
    dir_x_i <= it.dir[0]; dir_y_i <= it.dir[1]; dir_z_i <= it.dir[2];
    thrust_gain_i <= it.ct; torque_ratio_i <= it.km;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_rotor(it);
  endtask

  function automatic rotor_t mk(logic [3:0] rn, logic signed [15:0] px, py, pz,
                                dx, dy, dz, ct, km);
    rotor_t it;
    it.rotor = rn;
    it.pos = '{px, py, pz};
    it.dir = '{dx, dy, dz};
    it.ct = ct;
    it.km = km;
    return it;
  endfunction

  function automatic logic signed [15:0] pick16();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($signed($urandom_range(0, 4095)) - 2048);
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly in-range rotors with real axes; some zero axes, zero ct and stray indices
  function automatic rotor_t rand_rotor();
    rotor_t it;
    it.rotor = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15))
                                           : 4'($urandom_range(0, 11));
    for (int j = 0; j < 3; j++) begin
      it.pos[j] = pick16();
      it.dir[j] = pick16();
    end
    if ($urandom_range(0, 19) == 0) it.dir = '{16'sd0, 16'sd0, 16'sd0};
    it.ct = ($urandom_range(0, 19) == 0) ? 16'sd0 : pick16();
    it.km = pick16();
    return it;
  endfunction

  initial begin
    int unsigned cfg [8][3] = '{'{0, 12, 0}, '{15, 15, 1}, '{4, 0, 0}, '{0, 12, 1},
                               '{3, 7, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}};
    int unsigned idle_mode [4][2] = '{'{0, 0}, '{60, 0}, '{0, 60}, '{35, 35}};
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid_i = 1'b0; rotor_number_i = '0;
    pos_x_i = '0; pos_y_i = '0; pos_z_i = '0;
    dir_x_i = '0; dir_y_i = '0; dir_z_i = '0;
    thrust_gain_i = '0; torque_ratio_i = '0;
    out_ready_i = 1'b1;
    send_idle_pct = 0; recv_stall_pct = 0;
    quiet_cycles = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register at no address: must leave everything alone
    reg_write(BadRegAddr, 32'hFFFF_FFFF);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph >= 5) begin
        cfg[ph][0] = $urandom_range(0, 15);
        cfg[ph][1] = $urandom_range(0, 15);
        cfg[ph][2] = $urandom_range(0, 1);
      end
      send_idle_pct  = idle_mode[ph % 4][0];
      recv_stall_pct = idle_mode[ph % 4][1];
      configure(cfg[ph][0], cfg[ph][1], cfg[ph][2]);
      if (ph == 0) begin
        // field extremes, rotors out of range, zero axis, zero ct
        send_rotor(mk(0, 0, 0, 0, 0, 0, 16384, 256, 8192));
        send_rotor(mk(11, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                      16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
        send_rotor(mk(1, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                      16'sh8000, 16'sh8000, 16'sh8000));
        send_rotor(mk(2, 16'sh7FFF, 16'sh8000, 0, 16'sh8000, 0, 0, 16'sh7FFF, 16'sh8000));
        send_rotor(mk(3, 2048, -2048, 0, 0, 0, -16384, 1024, -8192));
        send_rotor(mk(4, 100, 200, 300, 0, 0, 0, 512, 100));
        send_rotor(mk(5, 100, 200, 300, 1, 2, 3, 0, 100));
        send_rotor(mk(12, 1, 1, 1, 1, 1, 1, 1, 1));
        send_rotor(mk(15, 16'sh7FFF, 0, 0, 0, 0, 1, 256, 0));
        send_rotor(mk(6, 0, 0, 0, 1, 0, 0, 1, 0));
        send_rotor(mk(7, 16'sh8000, 16'sh7FFF, 16'sh8000, 1, -1, 1, 16'sh8000, 16'sh7FFF));
        send_rotor(mk(8, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, 0, 16'sh8000, 0));
        send_rotor(mk(9, -1, -1, -1, -1, -1, -1, -1, -1));
        send_rotor(mk(10, 5000, -3000, 700, 0, 16'sh7FFF, 0, 16'sh7FFF, 16'sh8000));
      end
      for (int n = 0; n < 105; n++) send_rotor(rand_rotor());
    end

    in_valid_i <= 1'b0;
    while (sb.expected_cols.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
